>>> rtl/kms_pkg.sv
package kms_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 19;

    localparam int COL_IDX_W  = 5;
    localparam int ROW_BITS_W = 8;
    localparam int QROW_W     = 3;
    localparam int PASS_W     = 8;
    localparam int KCOUNT_W   = 8;

    localparam logic [PASS_W-1:0] PASS_RESET = 8'd5;

    localparam int CNT_W  = $clog2(ROW_COUNT * COLUMN_COUNT + 1);
    localparam int ROWC_W = $clog2(ROW_COUNT + 1);

    typedef logic [COLUMN_COUNT-1:0] row_t;
    typedef row_t [ROW_COUNT-1:0] matrix_t;

    typedef struct packed {
        logic             settled;
        logic             updated;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage

>>> rtl/kms_matrix.sv
module kms_matrix (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kms_pkg::PASS_W-1:0]     cfg_wr_data,
    input  logic                           step_en,
    input  logic [kms_pkg::COL_IDX_W-1:0]  scan_column,
    input  logic [kms_pkg::ROW_BITS_W-1:0] row_bits,
    input  logic                           end_of_scan,
    output kms_pkg::matrix_t               stable_next,
    output kms_pkg::status_t               status
);

    kms_pkg::matrix_t                raw_reg;
    kms_pkg::matrix_t                raw_next;
    kms_pkg::matrix_t                stable_reg;
    logic [kms_pkg::CNT_W-1:0]       raw_count_reg;
    logic [kms_pkg::CNT_W-1:0]       raw_count_next;
    logic [kms_pkg::CNT_W-1:0]       stable_count_reg;
    logic [kms_pkg::CNT_W-1:0]       stable_count_next;
    logic [kms_pkg::PASS_W-1:0]      passes_reg;
    logic [kms_pkg::PASS_W-1:0]      cnt_reg;
    logic [kms_pkg::PASS_W-1:0]      cnt_next;
    logic [kms_pkg::PASS_W-1:0]      cnt_load;
    kms_pkg::row_t                   col_mask;
    logic [kms_pkg::ROW_COUNT+kms_pkg::ROW_BITS_W-1:0] rows_ext;
    logic [kms_pkg::ROWC_W-1:0]      set_n;
    logic [kms_pkg::ROWC_W-1:0]      clr_n;
    logic                            any_change;
    logic                            updated;
    logic                            prev;
    logic                            cur;

    // column compare against the raw matrix
    always_comb begin
        col_mask = '0;
        if (32'(scan_column) < kms_pkg::COLUMN_COUNT) begin
            col_mask = kms_pkg::row_t'(1) << scan_column;
        end
        rows_ext   = {kms_pkg::ROW_COUNT'(0), row_bits};
        raw_next   = raw_reg;
        any_change = 1'b0;
        set_n      = '0;
        clr_n      = '0;
        prev       = 1'b0;
        cur        = 1'b0;
        for (int r = 0; r < kms_pkg::ROW_COUNT; r++) begin
            prev = |(raw_reg[r] & col_mask);
            cur  = rows_ext[r] & (|col_mask);
            if (cur != prev) begin
                raw_next[r] = raw_reg[r] ^ col_mask;
                any_change  = 1'b1;
                if (cur) begin
                    set_n = set_n + kms_pkg::ROWC_W'(1);
                end else begin
                    clr_n = clr_n + kms_pkg::ROWC_W'(1);
                end
            end
        end
        raw_count_next = raw_count_reg + kms_pkg::CNT_W'(set_n) - kms_pkg::CNT_W'(clr_n);
    end

    // debounce counter and copy
    always_comb begin
        cnt_load = any_change ? passes_reg : cnt_reg;
        cnt_next = cnt_load;
        updated  = 1'b0;
        if (end_of_scan && (cnt_load != '0)) begin
            cnt_next = cnt_load - kms_pkg::PASS_W'(1);
            updated  = (cnt_load == kms_pkg::PASS_W'(1));
        end
        stable_next       = updated ? raw_next : stable_reg;
        stable_count_next = updated ? raw_count_next : stable_count_reg;
    end

    assign status.settled = (cnt_next == '0);
    assign status.updated = updated;
    assign status.count   = stable_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg          <= '0;
            stable_reg       <= '0;
            raw_count_reg    <= '0;
            stable_count_reg <= '0;
            passes_reg       <= kms_pkg::PASS_RESET;
            cnt_reg          <= kms_pkg::PASS_RESET;
        end else begin
            if (cfg_wr_en) begin
                passes_reg <= cfg_wr_data;
            end
            if (step_en) begin
                raw_reg          <= raw_next;
                stable_reg       <= stable_next;
                raw_count_reg    <= raw_count_next;
                stable_count_reg <= stable_count_next;
                cnt_reg          <= cnt_next;
            end
        end
    end

endmodule

>>> rtl/kms_result.sv
module kms_result (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    output logic                           step_en,
    input  logic [kms_pkg::QROW_W-1:0]     query_row,
    input  logic [kms_pkg::COL_IDX_W-1:0]  query_column,
    input  kms_pkg::matrix_t               stable_next,
    input  kms_pkg::status_t               status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kms_pkg::row_t                  m_stable_row,
    output logic                           m_key_on,
    output logic                           m_settled,
    output logic [kms_pkg::KCOUNT_W-1:0]   m_key_count,
    output logic                           m_matrix_updated
);

    logic                           m_valid_reg;
    kms_pkg::row_t                  row_reg;
    kms_pkg::row_t                  row_next;
    logic                           key_reg;
    logic                           key_next;
    logic                           settled_reg;
    logic                           updated_reg;
    logic [kms_pkg::KCOUNT_W-1:0]   count_reg;
    logic [kms_pkg::KCOUNT_W-1:0]   count_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign step_en = s_valid && s_ready;

    // row select, key pick and saturated count
    always_comb begin
        row_next = '0;
        for (int r = 0; r < kms_pkg::ROW_COUNT; r++) begin
            if (32'(query_row) == r) begin
                row_next = stable_next[r];
            end
        end
        key_next = 1'b0;
        if (32'(query_column) < kms_pkg::COLUMN_COUNT) begin
            key_next = row_next[query_column];
        end
        if (32'(status.count) > 32'd255) begin
            count_next = kms_pkg::KCOUNT_W'(255);
        end else begin
            count_next = kms_pkg::KCOUNT_W'(status.count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            row_reg     <= row_next;
            key_reg     <= key_next;
            settled_reg <= status.settled;
            updated_reg <= status.updated;
            count_reg   <= count_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_stable_row     = row_reg;
    assign m_key_on         = key_reg;
    assign m_settled        = settled_reg;
    assign m_key_count      = count_reg;
    assign m_matrix_updated = updated_reg;

endmodule

>>> rtl/key_matrix_scan_debounce.sv
// keyboard matrix scan with a shared debounce counter
// s_ channel: one item per scanned column (row bits, end of pass flag) plus a
// query of one row and key of the stable matrix; valid/ready handshake
// m_ channel: one result item per input item, valid/ready handshake
// cfg_wr_en/cfg_wr_data write the debounce pass count at any idle edge;
// the write does not reload the running counter
// the result is registered and appears in the cycle after the item is accepted
// throughput: one item per cycle while results are taken; the matrix update, counter and query are one
// registered step, the key count is kept incrementally alongside the matrices
// a stalled result is held in the output register and s_ready drops until it
// is taken; while the output is empty or being taken s_ready stays high
// reset (aresetn low, synchronous): raw and stable matrices clear, the pass
// count and the counter return to 5, no result is pending
module key_matrix_scan_debounce (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kms_pkg::PASS_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kms_pkg::COL_IDX_W-1:0]  s_scan_column,
    input  logic [kms_pkg::ROW_BITS_W-1:0] s_row_bits,
    input  logic                           s_end_of_scan,
    input  logic [kms_pkg::QROW_W-1:0]     s_query_row,
    input  logic [kms_pkg::COL_IDX_W-1:0]  s_query_column,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kms_pkg::row_t                  m_stable_row,
    output logic                           m_key_on,
    output logic                           m_settled,
    output logic [kms_pkg::KCOUNT_W-1:0]   m_key_count,
    output logic                           m_matrix_updated
);

    logic             step_en;
    kms_pkg::matrix_t stable_next;
    kms_pkg::status_t status;

    kms_matrix u_matrix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .scan_column (s_scan_column),
        .row_bits    (s_row_bits),
        .end_of_scan (s_end_of_scan),
        .stable_next (stable_next),
        .status      (status)
    );

    kms_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .step_en          (step_en),
        .query_row        (s_query_row),
        .query_column     (s_query_column),
        .stable_next      (stable_next),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_stable_row     (m_stable_row),
        .m_key_on         (m_key_on),
        .m_settled        (m_settled),
        .m_key_count      (m_key_count),
        .m_matrix_updated (m_matrix_updated)
    );

    a_ready_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready
    ) else $error("input stalled with empty output register");

    a_stall_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |-> !s_ready
    ) else $error("item taken while result stalled");

    a_update_settles: assert property (
        @(posedge aclk) disable iff (!aresetn) (m_valid && m_matrix_updated) |-> m_settled
    ) else $error("matrix copied without settled counter");

    a_count_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_key_count) <= kms_pkg::ROW_COUNT * kms_pkg::COLUMN_COUNT)
    ) else $error("key count beyond matrix size");

endmodule
